FILE: rtl/mvsm_pkg.sv
// ----------------------------------------------------------------------------
// mvsm_pkg
// shared types and constants of the multi-voice sample mixer
// ----------------------------------------------------------------------------
package mvsm_pkg;

    localparam int VOICES          = 5;
    localparam int VOICE_W         = $clog2(VOICES);
    localparam int SUM_W           = 8 + $clog2(VOICES + 1);
    localparam int Q_DEPTH         = 2;
    localparam int STORE_DEPTH_DEF = 65536;

    localparam int SAT_HI = 127;
    localparam int SAT_LO = -128;

    localparam logic [16:0] MAX_LEN        = 17'h10000;
    localparam logic [15:0] INTERVAL_RESET = 16'd67;

    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_ADD   = 3'd3;
    localparam logic [2:0] CMD_WRITE = 3'd4;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_TICK,
        OP_START,
        OP_STOP,
        OP_ADD,
        OP_WRITE
    } t_op_kind;

    typedef struct packed {
        t_op_kind    kind;
        logic [15:0] addr;
        logic [16:0] len;
        logic        loops;
        logic [7:0]  sample;
    } t_op;

    typedef struct packed {
        logic               done;
        logic signed [7:0]  dac_value;
        logic               dac_write;
        logic               add_accepted;
        logic [VOICE_W-1:0] voice_slot;
        logic [VOICES-1:0]  active_voices;
    } t_result;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MIX,
        BK_FIN
    } t_back_state;

endpackage

FILE: rtl/mvsm_ram.sv
// ----------------------------------------------------------------------------
// mvsm_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module mvsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/mvsm_front.sv
// ----------------------------------------------------------------------------
// mvsm_front
// command decode and classification into a short operation queue
// ----------------------------------------------------------------------------
module mvsm_front
    import mvsm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [2:0]  i_cmd,
    input  logic [15:0] i_address,
    input  logic [16:0] i_length,
    input  logic        i_loop_mode,
    input  logic [7:0]  i_sample_byte,
    output logic        o_busy,
    output logic        o_q_valid,
    output t_op         o_q_op,
    input  logic        i_q_pop
);

    localparam int QP_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QC_W = $clog2(Q_DEPTH + 1);

    t_op             r_q [Q_DEPTH];
    logic [QP_W-1:0] r_wp, n_wp;
    logic [QP_W-1:0] r_rp, n_rp;
    logic [QC_W-1:0] r_cnt, n_cnt;
    t_op             w_op;
    logic            w_push;

    // classify the command
    always_comb begin
        w_op.addr   = i_address;
        w_op.len    = (i_length > MAX_LEN) ? MAX_LEN : i_length;
        w_op.loops  = i_loop_mode;
        w_op.sample = i_sample_byte;
        case (i_cmd)
            CMD_TICK:  w_op.kind = OP_TICK;
            CMD_START: w_op.kind = OP_START;
            CMD_STOP:  w_op.kind = OP_STOP;
            CMD_ADD:   w_op.kind = (i_length == 17'd0) ? OP_NONE : OP_ADD;
            CMD_WRITE: w_op.kind = OP_WRITE;
            default:   w_op.kind = OP_NONE;
        endcase
    end

    assign o_busy    = (r_cnt == QC_W'(Q_DEPTH));
    assign w_push    = i_start && !o_busy;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_op    = r_q[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wp = (r_wp == QP_W'(Q_DEPTH - 1)) ? '0 : r_wp + QP_W'(1);
        end
        if (i_q_pop) begin
            n_rp = (r_rp == QP_W'(Q_DEPTH - 1)) ? '0 : r_rp + QP_W'(1);
        end
        if (w_push && !i_q_pop) begin
            n_cnt = r_cnt + QC_W'(1);
        end else if (!w_push && i_q_pop) begin
            n_cnt = r_cnt - QC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_op;
        end
    end

endmodule

FILE: rtl/mvsm_back.sv
// ----------------------------------------------------------------------------
// mvsm_back
// operation execution: voice table, tick countdown and per-voice mix loop
// ----------------------------------------------------------------------------
module mvsm_back
    import mvsm_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [15:0]                    i_interval,
    input  logic                           i_q_valid,
    input  t_op                            i_q_op,
    output logic                           o_q_pop,
    output logic                           o_ram_we,
    output logic [$clog2(STORE_DEPTH)-1:0] o_ram_waddr,
    output logic [7:0]                     o_ram_wdata,
    output logic [$clog2(STORE_DEPTH)-1:0] o_ram_raddr,
    input  logic [7:0]                     i_ram_rdata,
    output t_result                        o_res
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam logic signed [SUM_W-1:0] L_HI = SUM_W'(SAT_HI);
    localparam logic signed [SUM_W-1:0] L_LO = SUM_W'(SAT_LO);

    t_back_state r_state, n_state;

    logic [VOICES-1:0]  r_used, n_used;
    logic [15:0]        r_pos [VOICES];
    logic [15:0]        n_pos [VOICES];
    logic [15:0]        r_start [VOICES];
    logic [16:0]        r_len [VOICES];
    logic [VOICES-1:0]  r_loops;
    logic               r_mixer_on, n_mixer_on;
    logic [15:0]        r_countdown, n_countdown;
    logic [VOICE_W-1:0] r_vidx, n_vidx;
    logic signed [SUM_W-1:0] r_acc, n_acc;
    logic               r_rd_pend, n_rd_pend;
    t_result            r_res, n_res;

    logic               w_load;
    logic [15:0]        w_iv;
    logic               w_update;
    logic               w_free_hit;
    logic [VOICE_W-1:0] w_free_idx;
    logic [16:0]        w_nxt;
    logic               w_wrap;
    logic [16:0]        w_rd_sum;
    logic signed [SUM_W-1:0] w_acc_sum;
    logic signed [7:0]  w_sat;

    assign w_iv     = (i_interval == 16'd0) ? 16'd1 : i_interval;
    assign o_q_pop  = (r_state == BK_IDLE) && i_q_valid;
    assign w_update = (i_q_op.kind == OP_TICK) && r_mixer_on && (r_countdown <= 16'd1);
    assign w_load   = o_q_pop && (i_q_op.kind == OP_ADD) && w_free_hit;

    // lowest free slot
    always_comb begin
        w_free_hit = 1'b0;
        w_free_idx = '0;
        for (int i = VOICES - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                w_free_hit = 1'b1;
                w_free_idx = VOICE_W'(i);
            end
        end
    end

    // current voice of the mix loop
    assign w_nxt    = {1'b0, r_pos[r_vidx]} + 17'd1;
    assign w_wrap   = (w_nxt >= r_len[r_vidx]);
    assign w_rd_sum = {1'b0, r_start[r_vidx]} + w_nxt;
    assign w_acc_sum = r_acc + (r_rd_pend ?
        {{(SUM_W - 8){i_ram_rdata[7]}}, i_ram_rdata} : SUM_W'(0));

    always_comb begin
        if (w_acc_sum > L_HI) begin
            w_sat = 8'sd127;
        end else if (w_acc_sum < L_LO) begin
            w_sat = -8'sd128;
        end else begin
            w_sat = w_acc_sum[7:0];
        end
    end

    assign o_ram_raddr = AW'(w_rd_sum);
    assign o_ram_waddr = AW'(i_q_op.addr);
    assign o_ram_wdata = i_q_op.sample;
    assign o_ram_we    = o_q_pop && (i_q_op.kind == OP_WRITE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (o_q_pop && w_update) begin
                    n_state = BK_MIX;
                end
            end
            BK_MIX: begin
                if (r_vidx == VOICE_W'(VOICES - 1)) begin
                    n_state = BK_FIN;
                end
            end
            BK_FIN:  n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    // datapath and results
    always_comb begin
        logic emit;
        emit        = 1'b0;
        n_used      = r_used;
        n_pos       = r_pos;
        n_mixer_on  = r_mixer_on;
        n_countdown = r_countdown;
        n_vidx      = r_vidx;
        n_acc       = r_acc;
        n_rd_pend   = 1'b0;
        n_res       = '0;
        case (r_state)
            BK_IDLE: begin
                if (o_q_pop) begin
                    case (i_q_op.kind)
                        OP_TICK: begin
                            if (w_update) begin
                                n_countdown = w_iv;
                                n_vidx      = '0;
                                n_acc       = '0;
                            end else begin
                                if (r_mixer_on) begin
                                    n_countdown = r_countdown - 16'd1;
                                end
                                emit = 1'b1;
                            end
                        end
                        OP_START: begin
                            n_used      = '0;
                            n_mixer_on  = 1'b1;
                            n_countdown = w_iv;
                            emit        = 1'b1;
                        end
                        OP_STOP: begin
                            n_mixer_on = 1'b0;
                            emit       = 1'b1;
                        end
                        OP_ADD: begin
                            if (w_free_hit) begin
                                n_used[w_free_idx] = 1'b1;
                                n_pos[w_free_idx]  = '0;
                                n_res.add_accepted = 1'b1;
                                n_res.voice_slot   = w_free_idx;
                            end
                            emit = 1'b1;
                        end
                        default: emit = 1'b1;
                    endcase
                end
            end
            BK_MIX: begin
                n_acc  = w_acc_sum;
                n_vidx = r_vidx + VOICE_W'(1);
                if (r_used[r_vidx]) begin
                    if (w_wrap) begin
                        n_pos[r_vidx] = '0;
                        if (!r_loops[r_vidx]) begin
                            n_used[r_vidx] = 1'b0;
                        end
                    end else begin
                        n_pos[r_vidx] = w_nxt[15:0];
                        n_rd_pend     = 1'b1;
                    end
                end
            end
            BK_FIN: begin
                n_res.dac_value = w_sat;
                n_res.dac_write = 1'b1;
                emit            = 1'b1;
            end
            default: begin
                n_res = '0;
            end
        endcase
        if (emit) begin
            n_res.done          = 1'b1;
            n_res.active_voices = n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_used      <= '0;
            r_pos       <= '{default: '0};
            r_mixer_on  <= 1'b0;
            r_countdown <= '0;
            r_vidx      <= '0;
            r_rd_pend   <= 1'b0;
            r_res       <= '0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_pos       <= n_pos;
            r_mixer_on  <= n_mixer_on;
            r_countdown <= n_countdown;
            r_vidx      <= n_vidx;
            r_rd_pend   <= n_rd_pend;
            r_res       <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (w_load) begin
            r_start[w_free_idx] <= i_q_op.addr;
            r_len[w_free_idx]   <= i_q_op.len;
            r_loops[w_free_idx] <= i_q_op.loops;
        end
    end

    assign o_res = r_res;

endmodule

FILE: rtl/multi_voice_sample_mixer.sv
// ----------------------------------------------------------------------------
// multi_voice_sample_mixer
// pcm sample store with up to five voices mixed and saturated to a dac value
// ----------------------------------------------------------------------------
// Commands enter a two-deep queue; busy is high only while that queue is
// full. Every command gives exactly one result, shown for one cycle with
// o_done; results cannot be held off. Commands that cause no dac update
// sustain one per cycle while no dac update is being mixed; their result
// is registered after the command has passed through the queue. A tick that
// causes a dac update holds the execution unit while it visits every voice
// in turn through the single read port of the sample store; no further
// command is taken from the queue meanwhile. STORE_DEPTH must be a power of
// two; store addresses wrap modulo STORE_DEPTH. There is no clearing pass
// after reset. The configuration port is always ready; write the sample
// interval only while no command is in flight.
// ----------------------------------------------------------------------------
module multi_voice_sample_mixer
    import mvsm_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [2:0]         i_cmd,
    input  logic [15:0]        i_address,
    input  logic [16:0]        i_length,
    input  logic               i_loop_mode,
    input  logic signed [7:0]  i_sample_byte,
    output logic               o_done,
    output logic signed [7:0]  o_dac_value,
    output logic               o_dac_write,
    output logic               o_add_accepted,
    output logic [2:0]         o_voice_slot,
    output logic [4:0]         o_active_voices,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_data
);

    localparam int AW = $clog2(STORE_DEPTH);

    logic [15:0]   r_sample_interval;
    logic          w_q_valid;
    t_op           w_q_op;
    logic          w_q_pop;
    logic          w_ram_we;
    logic [AW-1:0] w_ram_waddr;
    logic [7:0]    w_ram_wdata;
    logic [AW-1:0] w_ram_raddr;
    logic [7:0]    w_ram_rdata;
    t_result       w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_interval <= INTERVAL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_sample_interval <= i_cfg_data;
        end
    end

    mvsm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_cmd         (i_cmd),
        .i_address     (i_address),
        .i_length      (i_length),
        .i_loop_mode   (i_loop_mode),
        .i_sample_byte (i_sample_byte),
        .o_busy        (o_busy),
        .o_q_valid     (w_q_valid),
        .o_q_op        (w_q_op),
        .i_q_pop       (w_q_pop)
    );

    mvsm_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_interval  (r_sample_interval),
        .i_q_valid   (w_q_valid),
        .i_q_op      (w_q_op),
        .o_q_pop     (w_q_pop),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata),
        .o_res       (w_res)
    );

    mvsm_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    assign o_done          = w_res.done;
    assign o_dac_value     = w_res.dac_value;
    assign o_dac_write     = w_res.dac_write;
    assign o_add_accepted  = w_res.add_accepted;
    assign o_voice_slot    = w_res.voice_slot;
    assign o_active_voices = w_res.active_voices;

`ifndef SYNTHESIS
    a_slot_in_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_add_accepted |-> o_done && o_active_voices[o_voice_slot])
        else $error("granted slot missing from active mask");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_add_accepted |-> (o_voice_slot < 3'(VOICES)))
        else $error("granted slot out of range");

    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dac_write |-> o_done && !o_add_accepted)
        else $error("dac write and add on one result");

    a_quiet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_done |-> (o_dac_value == 8'sd0) && (o_active_voices == 5'd0))
        else $error("result fields set without transfer");
`endif

endmodule

FILE: tb/tb_multi_voice_sample_mixer.sv
// ----------------------------------------------------------------------------
// tb_multi_voice_sample_mixer
// self-checking bench for the multi-voice sample mixer: a scoreboard class
// tracks the sample store, the voice table, the mixer state and the sample
// interval, predicts the result of every accepted command and compares each
// o_done result field by field; directed corner cases come first, then
// random command sessions over several sample interval settings
// ----------------------------------------------------------------------------
module tb_multi_voice_sample_mixer import mvsm_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CMD_TOP       = 3'd7;
    localparam int         STALL_LIMIT   = 2000;
    localparam int         SETTLE_CYCLES = 12;
    localparam int         DRAIN_CYCLES  = 24;
    localparam int         PHASE_ITEMS   = 150;

    typedef struct packed {
        logic signed [7:0] dac_value;
        logic              dac_write;
        logic              add_accepted;
        logic [2:0]        voice_slot;
        logic [4:0]        active_voices;
    } t_mix_result;

    class mixer_scoreboard;
        logic [7:0]  store [STORE_DEPTH_DEF];
        bit          written [STORE_DEPTH_DEF];
        bit          used [VOICES];
        logic [15:0] position [VOICES];
        logic [15:0] start_addr [VOICES];
        logic [16:0] voice_len [VOICES];
        bit          loops [VOICES];
        bit          running;
        int unsigned countdown;
        logic [15:0] interval;
        t_mix_result expected_q [$];
        int          errors, checked, commands, updates, saturated, adds_taken, adds_dropped;

        function new();
            foreach (store[i]) begin
                store[i]   = '0;
                written[i] = 1'b0;
            end
            foreach (used[i]) begin
                used[i]       = 1'b0;
                position[i]   = '0;
                start_addr[i] = '0;
                voice_len[i]  = '0;
                loops[i]      = 1'b0;
            end
            running   = 1'b0;
            countdown = 0;
            interval  = INTERVAL_RESET;
        endfunction

        function void set_interval(logic [15:0] v);
            interval = v;
        endfunction

        function int unsigned step_interval();
            return (interval == 0) ? 1 : interval;
        endfunction

        function logic [4:0] used_mask();
            logic [4:0] m;
            m = '0;
            foreach (used[i])
                if (used[i]) m[i] = 1'b1;
            return m;
        endfunction

        function int voices_in_use();
            return $countones(used_mask());
        endfunction

        function bit update_due();
            return running && countdown <= 1;
        endfunction

        // next update would read a store entry that was never written
        function bit unwritten_read(output logic [15:0] addr);
            int unsigned nxt;
            addr = '0;
            for (int i = 0; i < VOICES; i++) begin
                nxt = position[i] + 1;
                if (used[i] && nxt < voice_len[i]) begin
                    addr = 16'(start_addr[i] + nxt);
                    if (!written[addr]) return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function logic signed [7:0] mix_voices();
            int          sum;
            int unsigned nxt;
            logic [15:0] a;
            sum = 0;
            for (int i = 0; i < VOICES; i++) begin
                if (!used[i]) continue;
                nxt = position[i] + 1;
                if (nxt >= voice_len[i]) begin
                    position[i] = '0;
                    if (!loops[i]) used[i] = 1'b0;
                end else begin
                    a           = 16'(start_addr[i] + nxt);
                    position[i] = 16'(nxt);
                    sum         = sum + int'($signed(store[a]));
                end
            end
            if (sum > SAT_HI || sum < SAT_LO) saturated++;
            if (sum > SAT_HI) sum = SAT_HI;
            if (sum < SAT_LO) sum = SAT_LO;
            return 8'(sum);
        endfunction

        function void note_command(logic [2:0] cmd, logic [15:0] addr, logic [16:0] len,
                                   logic lp, logic [7:0] data);
            t_mix_result r;
            logic [16:0] l;
            r = '0;
            commands++;
            case (cmd)
                CMD_TICK: begin
                    if (running) begin
                        if (countdown > 1) begin
                            countdown--;
                        end else begin
                            r.dac_value = mix_voices();
                            r.dac_write = 1'b1;
                            countdown   = step_interval();
                            updates++;
                        end
                    end
                end
                CMD_START: begin
                    foreach (used[i]) used[i] = 1'b0;
                    running   = 1'b1;
                    countdown = step_interval();
                end
                CMD_STOP: begin
                    running = 1'b0;
                end
                CMD_ADD: begin
                    if (len != 0) begin
                        l = (len > MAX_LEN) ? MAX_LEN : len;
                        for (int i = 0; i < VOICES; i++) begin
                            if (!used[i]) begin
                                used[i]         = 1'b1;
                                position[i]     = '0;
                                start_addr[i]   = addr;
                                voice_len[i]    = l;
                                loops[i]        = lp;
                                r.add_accepted  = 1'b1;
                                r.voice_slot    = 3'(i);
                                break;
                            end
                        end
                    end
                    if (r.add_accepted) adds_taken++;
                    else adds_dropped++;
                end
                CMD_WRITE: begin
                    store[addr]   = data;
                    written[addr] = 1'b1;
                end
                default: ;
            endcase
            r.active_voices = used_mask();
            expected_q.push_back(r);
        endfunction

        task report_mismatch(string what);
            $display("mismatch at result %0d: %s", checked, what);
            errors++;
        endtask

        task compare_field(string name, int got, int want);
            if (got != want)
                report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        endtask

        task check_result(t_mix_result got);
            t_mix_result want;
            checked++;
            if (expected_q.size() == 0) begin
                report_mismatch("result with no command outstanding");
                return;
            end
            want = expected_q.pop_front();
            compare_field("dac_value", int'(got.dac_value), int'(want.dac_value));
            compare_field("dac_write", got.dac_write, want.dac_write);
            compare_field("add_accepted", got.add_accepted, want.add_accepted);
            compare_field("voice_slot", got.voice_slot, want.voice_slot);
            compare_field("active_voices", got.active_voices, want.active_voices);
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic               o_busy;
    logic [2:0]         i_cmd = CMD_TICK;
    logic [15:0]        i_address = '0;
    logic [16:0]        i_length = '0;
    logic               i_loop_mode = 1'b0;
    logic signed [7:0]  i_sample_byte = '0;
    logic               o_done;
    logic signed [7:0]  o_dac_value;
    logic               o_dac_write;
    logic               o_add_accepted;
    logic [2:0]         o_voice_slot;
    logic [4:0]         o_active_voices;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [15:0]        i_cfg_data = '0;

    mixer_scoreboard sb = new();
    int              stall_cycles = 0;
    bit              idle_on = 1'b1;

    multi_voice_sample_mixer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_cmd           (i_cmd),
        .i_address       (i_address),
        .i_length        (i_length),
        .i_loop_mode     (i_loop_mode),
        .i_sample_byte   (i_sample_byte),
        .o_done          (o_done),
        .o_dac_value     (o_dac_value),
        .o_dac_write     (o_dac_write),
        .o_add_accepted  (o_add_accepted),
        .o_voice_slot    (o_voice_slot),
        .o_active_voices (o_active_voices),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            sb.check_result('{o_dac_value, o_dac_write, o_add_accepted, o_voice_slot,
                              o_active_voices});
        if (!i_rst_n || (i_start && !o_busy) || o_done || (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("no transfer for %0d cycles", STALL_LIMIT);
        $display("FAIL");
        $finish;
    end

    task automatic send_command(logic [2:0] cmd, logic [15:0] addr, logic [16:0] len,
                                logic lp, logic [7:0] data);
        @(negedge i_clk);
        i_start       <= 1'b1;
        i_cmd         <= cmd;
        i_address     <= addr;
        i_length      <= len;
        i_loop_mode   <= lp;
        i_sample_byte <= data;
        do @(posedge i_clk); while (o_busy);
        sb.note_command(cmd, addr, len, lp, data);
    endtask

    task automatic pause_sender(int n);
        @(negedge i_clk);
        i_start <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic maybe_idle();
        if (idle_on && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 8));
    endtask

    task automatic send_plain(logic [2:0] cmd);
        send_command(cmd, 16'($urandom), 17'($urandom), 1'($urandom), 8'($urandom));
    endtask

    // fill any store entry the coming update will read, then tick
    task automatic send_tick();
        logic [15:0] a;
        while (sb.update_due() && sb.unwritten_read(a))
            send_command(CMD_WRITE, a, 17'($urandom), 1'($urandom), 8'($urandom));
        send_plain(CMD_TICK);
    endtask

    task automatic send_random_add();
        logic [16:0] len;
        logic [15:0] addr;
        case ($urandom_range(0, 19))
            0:       len = '0;
            1:       len = MAX_LEN;
            2:       len = 17'($urandom);
            3, 4:    len = 17'($urandom_range(1, 300));
            default: len = 17'($urandom_range(1, 12));
        endcase
        case ($urandom_range(0, 9))
            0:       addr = 16'($urandom_range(16'hFFF0, 16'hFFFF));
            1, 2, 3: addr = 16'($urandom);
            default: addr = 16'($urandom_range(0, 63));
        endcase
        send_command(CMD_ADD, addr, len, 1'($urandom), 8'($urandom));
    endtask

    task automatic send_random_item();
        int k;
        k = $urandom_range(0, 99);
        if (!sb.running && $urandom_range(0, 2) == 0)
            send_plain(CMD_START);
        else if (k < 55)
            send_tick();
        else if (k < 70)
            send_random_add();
        else if (k < 86)
            send_command(CMD_WRITE,
                         $urandom_range(0, 1) ? 16'($urandom_range(0, 63)) : 16'($urandom),
                         17'($urandom), 1'($urandom), 8'($urandom));
        else if (k < 90)
            send_plain(CMD_START);
        else if (k < 93)
            send_plain(CMD_STOP);
        else if (k < 95)
            send_plain(3'($urandom_range(int'(CMD_WRITE) + 1, int'(CMD_TOP))));
        else
            send_tick();
    endtask

    task automatic write_interval(logic [15:0] v);
        @(negedge i_clk);
        i_start <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_interval(v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [15:0] intervals [8];
        int          n;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners, interval 1 so every tick while running updates
        write_interval(16'd1);
        send_command(CMD_WRITE, 16'h0001, '0, 1'b0, 8'h7F);
        send_command(CMD_WRITE, 16'h0002, '0, 1'b0, 8'h7F);
        send_command(CMD_WRITE, 16'hFFFF, '0, 1'b0, 8'h80);
        send_command(CMD_WRITE, 16'h0000, '0, 1'b0, 8'h80);
        send_tick();
        send_command(CMD_ADD, 16'h0000, 17'd0, 1'b1, 8'h00);
        send_command(CMD_ADD, 16'hFFFE, 17'h1FFFF, 1'b1, 8'hFF);
        for (int c = int'(CMD_WRITE) + 1; c <= int'(CMD_TOP); c++) send_plain(3'(c));
        send_plain(CMD_START);
        send_tick();
        repeat (VOICES) send_command(CMD_ADD, 16'h0000, 17'd3, 1'b1, 8'h00);
        send_command(CMD_ADD, 16'h0000, 17'd3, 1'b1, 8'h00);
        repeat (3) send_tick();
        send_plain(CMD_START);
        repeat (2) send_command(CMD_ADD, 16'hFFFE, 17'd2, 1'b0, 8'h00);
        repeat (2) send_tick();
        send_command(CMD_ADD, 16'h0005, 17'd1, 1'b0, 8'h00);
        send_tick();
        send_plain(CMD_STOP);
        send_tick();

        intervals = '{16'd1, 16'd0, 16'd3, INTERVAL_RESET, 16'hFFFF, 16'd2,
                      16'($urandom_range(1, 8)), 16'd1};
        foreach (intervals[p]) begin
            write_interval(intervals[p]);
            idle_on = (p != 7) && (p % 3 != 2);
            n = (intervals[p] == 16'hFFFF) ? 24 : PHASE_ITEMS;
            send_plain(CMD_START);
            repeat (n) begin
                maybe_idle();
                send_random_item();
            end
        end

        @(negedge i_clk);
        i_start <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d commands: %0d dac updates (%0d clipped)",
                 sb.commands, sb.updates, sb.saturated);
        $display("%0d voices added, %0d adds refused; checked %0d results, %0d mismatches",
                 sb.adds_taken, sb.adds_dropped, sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
